>>> src/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned EventW   = 2;
  localparam int unsigned AdcWordW = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  // Number of leading payload bytes kept for message decode
  localparam int unsigned HeadDepth = 7;
  localparam int unsigned HeadIdxW  = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRxEnable  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPingValue = 8'd1;

  // Frame event codes
  localparam logic [EventW-1:0] EvNone    = 2'd0;
  localparam logic [EventW-1:0] EvGood    = 2'd1;
  localparam logic [EventW-1:0] EvBadSum  = 2'd2;

  // Link protocol bytes
  localparam logic [ByteW-1:0] SyncFirst  = 8'hFF;
  localparam logic [ByteW-1:0] SyncSecond = 8'h55;
  localparam logic [ByteW-1:0] AdcMark    = 8'h05;
  localparam logic [ByteW-1:0] PingMark   = 8'h44;
  localparam logic [ByteW-1:0] PingLead   = 8'h00;

  // Minimum payload lengths for each message type
  localparam logic [ByteW-1:0] AdcMinLen  = 8'd6;
  localparam logic [ByteW-1:0] PingMinLen = 8'd7;

  typedef struct packed {
    logic [EventW-1:0]   frame_event;
    logic                in_frame;
    logic [ByteW-1:0]    payload_length;
    logic                adc_valid;
    logic [AdcWordW-1:0] adc_word;
    logic                ping_reply;
  } res_t;

endpackage

>>> src/sfr_if.sv
`timescale 1ns / 1ps

interface sfr_byte_if;
  logic                    valid;
  logic                    ready;
  logic [sfr_pkg::ByteW-1:0] rx_byte;
  logic                    chunk_last;

  modport source (output valid, output rx_byte, output chunk_last, input ready);
  modport sink   (input valid, input rx_byte, input chunk_last, output ready);
endinterface

interface sfr_res_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::EventW-1:0]   frame_event;
  logic                         in_frame;
  logic [sfr_pkg::ByteW-1:0]    payload_length;
  logic                         adc_valid;
  logic [sfr_pkg::AdcWordW-1:0] adc_word;
  logic                         ping_reply;

  modport source (output valid, output frame_event, output in_frame,
                  output payload_length, output adc_valid, output adc_word,
                  output ping_reply, input ready);
  modport sink   (input valid, input frame_event, input in_frame,
                  input payload_length, input adc_valid, input adc_word,
                  input ping_reply, output ready);
endinterface

interface sfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::CfgIdxW-1:0]  index;
  logic [sfr_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/sync_frame_receiver_with_dispatch.sv
`timescale 1ns / 1ps

// Sync/length/checksum frame receiver with message dispatch.
// in_i  : one received link byte per transaction (rx_byte, chunk_last).
// out_o : exactly one result transaction per accepted byte, in order:
//         frame event, in-frame flag, payload length, ADC word, ping match.
// cfg_i : register writes; index 0 is rx_enable, index 1 is ping_value.
//         Writes to other indexes are accepted and dropped. Write only while
//         no result is outstanding.
// Timing: a byte's result is registered and shows on out_o in the cycle after
// the byte is accepted. Throughput: one byte per cycle while the receiver
// takes each result; the deframer state and result register update per byte.
// Stall: in_i.ready is high while the result register is empty or being
// taken this cycle; when the receiver holds off out_o the result holds and
// in_i stalls until it is taken.
// Reset: hunting for the first sync byte, no result pending, rx_enable 1,
// ping_value 0. No clearing pass is needed.
module sync_frame_receiver_with_dispatch (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfr_byte_if.sink  in_i,
  sfr_res_if.source out_o,
  sfr_cfg_if.sink   cfg_i
);
  import sfr_pkg::*;

  logic             rx_enable_q;
  logic [ByteW-1:0] ping_value_q;
  logic             in_accept;
  logic             out_valid;
  res_t             step_res;
  res_t             out_res;

  // Config writes are always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_enable_q  <= 1'b1;
      ping_value_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegRxEnable:  rx_enable_q  <= cfg_i.data[0];
        RegPingValue: ping_value_q <= cfg_i.data[ByteW-1:0];
        default:      ;
      endcase
    end
  end

  // Take a new byte whenever the result slot frees up this cycle
  assign in_i.ready = !out_valid || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  sfr_deframer u_deframer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_accept),
    .rx_byte_i    (in_i.rx_byte),
    .rx_enable_i  (rx_enable_q),
    .ping_value_i (ping_value_q),
    .res_o        (step_res)
  );

  sfr_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_accept),
    .res_i   (step_res),
    .ready_i (out_o.ready),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign out_o.valid          = out_valid;
  assign out_o.frame_event    = out_res.frame_event;
  assign out_o.in_frame       = out_res.in_frame;
  assign out_o.payload_length = out_res.payload_length;
  assign out_o.adc_valid      = out_res.adc_valid;
  assign out_o.adc_word       = out_res.adc_word;
  assign out_o.ping_reply     = out_res.ping_reply;

endmodule

>>> src/sfr_deframer.sv
`timescale 1ns / 1ps

module sfr_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [sfr_pkg::ByteW-1:0] rx_byte_i,
  input  logic                      rx_enable_i,
  input  logic [sfr_pkg::ByteW-1:0] ping_value_i,
  output sfr_pkg::res_t             res_o
);
  import sfr_pkg::*;

  localparam logic [1:0] StHuntFirst  = 2'd0;
  localparam logic [1:0] StHuntSecond = 2'd1;
  localparam logic [1:0] StLength     = 2'd2;
  localparam logic [1:0] StBody       = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [ByteW-1:0] taken_q, taken_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] head_q [HeadDepth];
  logic             head_we;
  logic [ByteW-1:0] payload;
  logic             ping_match;
  res_t             res;

  assign payload = len_q - 8'd1;

  always_comb begin
    ping_match = 1'b1;
    for (int i = 2; i < HeadDepth; i++) begin
      if (head_q[i] != ping_value_i) begin
        ping_match = 1'b0;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    taken_d = taken_q;
    len_d   = len_q;
    sum_d   = sum_q;
    head_we = 1'b0;
    res     = '0;
    if (rx_enable_i) begin
      unique case (phase_q)
        StHuntFirst: begin
          if (rx_byte_i == SyncFirst) begin
            phase_d = StHuntSecond;
          end
        end
        StHuntSecond: begin
          if (rx_byte_i == SyncFirst) begin
            phase_d = StHuntSecond;
          end else if (rx_byte_i == SyncSecond) begin
            phase_d = StLength;
          end else begin
            phase_d = StHuntFirst;
          end
        end
        StLength: begin
          // Zero length: drop the frame
          if (rx_byte_i == '0) begin
            phase_d = StHuntFirst;
          end else begin
            phase_d = StBody;
            taken_d = '0;
            len_d   = rx_byte_i;
            sum_d   = rx_byte_i;
          end
        end
        StBody: begin
          if (taken_q < payload) begin
            head_we = (taken_q < ByteW'(HeadDepth));
            sum_d   = sum_q + rx_byte_i;
            taken_d = taken_q + 8'd1;
          end else begin
            // Checksum byte
            phase_d            = StHuntFirst;
            res.payload_length = payload;
            if (sum_q == rx_byte_i) begin
              res.frame_event = EvGood;
              if (payload >= AdcMinLen && head_q[0] == AdcMark && head_q[1] == AdcMark) begin
                res.adc_valid = 1'b1;
                res.adc_word  = {head_q[5], head_q[4], head_q[3], head_q[2]};
              end
              if (payload >= PingMinLen && head_q[0] == PingLead && head_q[1] == PingMark &&
                  ping_match) begin
                res.ping_reply = 1'b1;
              end
            end else begin
              res.frame_event = EvBadSum;
            end
          end
        end
        default: begin
          phase_d = StHuntFirst;
        end
      endcase
    end
    res.in_frame = phase_d[1];
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= StHuntFirst;
      taken_q <= '0;
      len_q   <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      taken_q <= taken_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HeadDepth; i++) begin
      if (step_i && head_we && taken_q[HeadIdxW-1:0] == HeadIdxW'(i)) begin
        head_q[i] <= rx_byte_i;
      end
    end
  end

endmodule

>>> src/sfr_out_stage.sv
`timescale 1ns / 1ps

module sfr_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sfr_pkg::res_t res_i,
  input  logic          ready_i,
  output logic          valid_o,
  output sfr_pkg::res_t res_o
);
  import sfr_pkg::*;

  logic valid_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> src/sfr_checker.sv
`timescale 1ns / 1ps

module sfr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [sfr_pkg::EventW-1:0]   frame_event_i,
  input logic                         in_frame_i,
  input logic [sfr_pkg::ByteW-1:0]    payload_length_i,
  input logic                         adc_valid_i,
  input logic [sfr_pkg::AdcWordW-1:0] adc_word_i,
  input logic                         ping_reply_i
);
  import sfr_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_event_i) &&
      $stable(payload_length_i) && $stable(adc_word_i))
    else $error("stalled result changed");

  // A frame event always closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_event_i != EvNone |-> !in_frame_i)
    else $error("frame event while still in frame");

  // No event means no length and no decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_event_i == EvNone |->
      payload_length_i == '0 && !adc_valid_i && !ping_reply_i)
    else $error("decode fields set without a frame event");

  // ADC decode only on a good frame that is long enough, never with a ping reply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && adc_valid_i |->
      frame_event_i == EvGood && payload_length_i >= AdcMinLen && !ping_reply_i)
    else $error("bad ADC decode");

  // Ping match only on a good frame that is long enough; ADC word clear otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !adc_valid_i |-> adc_word_i == '0 &&
      (!ping_reply_i || (frame_event_i == EvGood && payload_length_i >= PingMinLen)))
    else $error("bad ping decode or stray ADC word");

endmodule

bind sync_frame_receiver_with_dispatch sfr_checker u_sfr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .frame_event_i    (out_o.frame_event),
  .in_frame_i       (out_o.in_frame),
  .payload_length_i (out_o.payload_length),
  .adc_valid_i      (out_o.adc_valid),
  .adc_word_i       (out_o.adc_word),
  .ping_reply_i     (out_o.ping_reply)
);
